@@ src/rgb_convolution_clamp_core_assert.svh @@
// Assertion macros shared by the convolution core.
`ifndef RGB_CONVOLUTION_CLAMP_CORE_ASSERT_SVH
`define RGB_CONVOLUTION_CLAMP_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define RCC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("rcc assertion failed");
`define RCC_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("rcc forbidden condition seen");
`else
`define RCC_ASSERT(lbl, prop)
`define RCC_NEVER(lbl, cond)
`endif
`endif

@@ src/rcc_pkg.sv @@
package rcc_pkg;

    localparam int MAX_KERNEL_DEF = 5;
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int COEF_FRAC_DEF  = 8;

    localparam int PIX_W  = 8;
    localparam int COEF_W = 16;
    localparam int RGB_W  = 3 * PIX_W;
    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    // Request kinds carried on the input user field.
    localparam logic [1:0] REQ_COEF  = 2'd0;
    localparam logic [1:0] REQ_PIX   = 2'd1;
    localparam logic [1:0] REQ_FLUSH = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_KSIZE  = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;

    localparam int CFG_W     = 11;
    localparam int OUT_DEPTH = 8;

    typedef struct packed {
        logic emit;
        logic last;
    } ctl_t;

    typedef struct packed {
        logic             last;
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
    } out_item_t;

endpackage

@@ src/rcc_linebuf.sv @@
module rcc_linebuf #(
    parameter int MAX_KERNEL = rcc_pkg::MAX_KERNEL_DEF,
    parameter int MAX_WIDTH  = rcc_pkg::MAX_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              step,
    input  logic [$clog2(MAX_WIDTH)-1:0]      col,
    input  logic [rcc_pkg::RGB_W-1:0]         pix,
    output logic [rcc_pkg::RGB_W-1:0]         win [MAX_KERNEL*MAX_KERNEL]
);
    import rcc_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int MK = MAX_KERNEL;

    logic             v1_reg;
    logic [CW-1:0]    col1_reg;
    logic [RGB_W-1:0] pix1_reg;
    logic             fwd_reg;
    logic [RGB_W-1:0] rd_reg       [MK];
    logic [RGB_W-1:0] fwd_data_reg [MK];
    logic [RGB_W-1:0] colv         [MK];
    logic [RGB_W-1:0] win_reg      [MK][MK];

    // Column entering the window: newest pixel on top, older rows below.
    // A step that hits the column written in the same cycle takes the bypass.
    always_comb
    begin
        colv[0] = pix1_reg;
        for (int k = 0; k < MK - 1; k++)
        begin
            colv[k+1] = fwd_reg ? fwd_data_reg[k] : rd_reg[k];
        end
    end

    for (genvar k = 0; k < MK - 1; k++)
    begin : g_row
        logic [RGB_W-1:0] mem [MAX_WIDTH];

        always_ff @(posedge clk)
        begin
            if (step)
            begin
                rd_reg[k] <= mem[col];
            end
            if (v1_reg)
            begin
                mem[col1_reg] <= colv[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            fwd_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= step;
            if (step)
            begin
                fwd_reg <= v1_reg && (col == col1_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            col1_reg <= col;
            pix1_reg <= pix;
            for (int k = 0; k < MK; k++)
            begin
                fwd_data_reg[k] <= colv[k];
            end
        end
        if (v1_reg)
        begin
            for (int a = MK - 1; a > 0; a--)
            begin
                win_reg[a] <= win_reg[a-1];
            end
            win_reg[0] <= colv;
        end
    end

    always_comb
    begin
        for (int a = 0; a < MK; a++)
        begin
            for (int d = 0; d < MK; d++)
            begin
                win[a*MK+d] = win_reg[a][d];
            end
        end
    end

endmodule

@@ src/rcc_lane.sv @@
module rcc_lane #(
    parameter int MAX_KERNEL = rcc_pkg::MAX_KERNEL_DEF,
    parameter int COEF_FRAC  = rcc_pkg::COEF_FRAC_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic [rcc_pkg::PIX_W-1:0]         pix  [MAX_KERNEL*MAX_KERNEL],
    input  logic signed [rcc_pkg::COEF_W-1:0] coef [MAX_KERNEL*MAX_KERNEL],
    output logic                              out_valid,
    output logic [rcc_pkg::PIX_W-1:0]         out_pix
);
    import rcc_pkg::*;

    localparam int MK  = MAX_KERNEL;
    localparam int NT  = MK * MK;
    localparam int PW  = PIX_W + COEF_W + 1;
    localparam int RSW = PW + $clog2(MK + 1);
    localparam int ASW = RSW + $clog2(MK + 1);

    logic signed [PW-1:0]  prod_reg [NT];
    logic signed [RSW-1:0] row_reg  [MK];
    logic signed [RSW-1:0] row_sum  [MK];
    logic signed [ASW-1:0] acc;
    logic [ASW-1:0]        shifted;
    logic [PIX_W-1:0]      clamped;
    logic [PIX_W-1:0]      out_reg;
    logic [2:0]            v_reg;

    always_comb
    begin
        for (int r = 0; r < MK; r++)
        begin
            row_sum[r] = '0;
            for (int c = 0; c < MK; c++)
            begin
                row_sum[r] = row_sum[r] + RSW'(prod_reg[r*MK+c]);
            end
        end
    end

    // Floor by the fraction bits, then clamp into the pixel range.
    always_comb
    begin
        acc = '0;
        for (int r = 0; r < MK; r++)
        begin
            acc = acc + ASW'(row_reg[r]);
        end
        shifted = ASW'(acc) >> COEF_FRAC;
        if (acc[ASW-1])
        begin
            clamped = '0;
        end
        else if (shifted > ASW'(PIX_MAX))
        begin
            clamped = PIX_MAX;
        end
        else
        begin
            clamped = shifted[PIX_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int t = 0; t < NT; t++)
        begin
            prod_reg[t] <= PW'($signed({1'b0, pix[t]})) * PW'(coef[t]);
        end
        row_reg <= row_sum;
        out_reg <= clamped;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[1:0], in_valid};
        end
    end

    assign out_valid = v_reg[2];
    assign out_pix   = out_reg;

endmodule

@@ src/rgb_convolution_clamp_core.sv @@
// RGB 2D convolution with zero padding and clamping to 0..255.
// Input stream: s_tuser selects the request (coefficient load, pixel, flush),
// s_tdata carries the coefficient index and value and the pixel channels.
// Output stream: one filtered pixel per result, m_tlast marks the last pixel
// of a frame. Configuration is written through cfg_we/cfg_addr/cfg_wdata and
// restarts the frame; it must only be written while the block is idle.
// Pixel k of a frame comes out when pixel k + off*W + off is taken, where off
// is half the kernel side; flush requests after the last pixel release the
// remaining outputs, one each.
// Throughput is one request per clock while s_tready is high. A result is
// released by the request that completes its window: the taking edge starts
// the line-buffer read, then follow the window shift, the channel lane stages
// (multiply, row sums, total and clamp) and the write to the output queue,
// after which the result shows on m_tvalid.
// For images with fewer pixels than off*W + off the block holds s_tready low
// after the last pixel until the position, advanced without input, catches up.
// Reset clears positions and coefficients and restores size 3, 640 x 480;
// the line buffers are not cleared. When m_tready stays low the 8-entry output
// queue fills and s_tready drops once every entry is spoken for.
module rgb_convolution_clamp_core #(
    parameter int MAX_KERNEL = rcc_pkg::MAX_KERNEL_DEF,
    parameter int MAX_WIDTH  = rcc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = rcc_pkg::MAX_HEIGHT_DEF,
    parameter int COEF_FRAC  = rcc_pkg::COEF_FRAC_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // coef_index[4:0], coef_value[20:5], pix_red[28:21], pix_green[36:29],
    // pix_blue[44:37], zero fill [47:45]
    input  logic [47:0]                s_tdata,
    // req_type[1:0]
    input  logic [1:0]                 s_tuser,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // out_red[7:0], out_green[15:8], out_blue[23:16]
    output logic [23:0]                m_tdata,
    output logic                       m_tlast,
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_addr,
    input  logic [rcc_pkg::CFG_W-1:0]  cfg_wdata
);
    import rcc_pkg::*;

`include "rgb_convolution_clamp_core_assert.svh"

    localparam int MK    = MAX_KERNEL;
    localparam int NT    = MK * MK;
    localparam int HALF  = MK / 2;
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int OFW   = $clog2(MK + 1);
    localparam int CNT_W = $clog2(MAX_WIDTH * MAX_HEIGHT + MK * MAX_WIDTH) + 1;
    localparam int PTR_W = $clog2(OUT_DEPTH);
    localparam int FCW   = $clog2(OUT_DEPTH + 1);

    // Configuration and derived frame geometry.
    logic [2:0]       ksize_reg;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [WW-1:0]    w_eff;
    logic [HW-1:0]    h_eff;
    logic [OFW-1:0]   off;
    logic [CNT_W-1:0] delay;
    logic [CNT_W-1:0] total;

    // Frame positions.
    logic [CNT_W-1:0] vcnt_reg;
    logic [CNT_W-1:0] out_cnt_reg;
    logic [CW-1:0]    pc_reg;
    logic [HW-1:0]    oi_reg;
    logic [WW-1:0]    oj_reg;
    logic             complete_reg;

    logic [1:0]         req;
    logic [4:0]         in_cidx;
    logic [COEF_W-1:0]  in_cval;
    logic [RGB_W-1:0]   in_pix;
    logic               acc_in;
    logic               pad_active;
    logic               is_pix;
    logic               is_flush;
    logic               step;
    logic               emit;
    logic               last;
    logic               cfg_hit;
    logic [MK-1:0]      rmask;
    logic [MK-1:0]      cmask;

    // Request pipeline.
    ctl_t               ctl_reg [5];
    logic [MK-1:0]      rm0_reg, cm0_reg, rm1_reg, cm1_reg;
    logic               cw0_reg, cw1_reg;
    logic [4:0]         cidx0_reg, cidx1_reg;
    logic [COEF_W-1:0]  cval0_reg, cval1_reg;
    logic signed [COEF_W-1:0] kstore_reg [NT];
    logic signed [COEF_W-1:0] coef_tap   [NT];

    logic [RGB_W-1:0]   win [NT];
    logic [PIX_W-1:0]   lane_pix [3][NT];
    logic [PIX_W-1:0]   lane_out [3];
    logic [2:0]         lane_vld;

    // Output queue.
    out_item_t          fifo_reg [OUT_DEPTH];
    logic [PTR_W-1:0]   wptr_reg, rptr_reg;
    logic [FCW-1:0]     fcnt_reg;
    logic [FCW-1:0]     used_reg;
    logic               push;
    logic               pop;

    assign req     = s_tuser;
    assign in_cidx = s_tdata[4:0];
    assign in_cval = s_tdata[20:5];
    assign in_pix  = s_tdata[44:21];

    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = WW'(1);
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(width_reg);
        end
        if (height_reg == '0)
        begin
            h_eff = HW'(1);
        end
        else if (32'(height_reg) > MAX_HEIGHT)
        begin
            h_eff = HW'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = HW'(height_reg);
        end
        if (32'(ksize_reg[2:1]) > HALF)
        begin
            off = OFW'(HALF);
        end
        else
        begin
            off = OFW'(ksize_reg[2:1]);
        end
        delay = CNT_W'(off) * CNT_W'(w_eff) + CNT_W'(off);
        total = CNT_W'(w_eff) * CNT_W'(h_eff);
    end

    // Tiny frames finish before the window reaches the first output; the
    // position is then advanced without input until it catches up.
    assign pad_active = complete_reg && (vcnt_reg < out_cnt_reg + delay);
    assign s_tready   = !pad_active && (used_reg < FCW'(OUT_DEPTH));
    assign acc_in     = s_tvalid && s_tready;
    assign is_pix     = acc_in && (req == REQ_PIX) && !complete_reg;
    assign is_flush   = acc_in && (req == REQ_FLUSH) && complete_reg
                        && (out_cnt_reg < total);
    assign step       = is_pix || is_flush || pad_active;
    assign emit       = is_flush || (is_pix && (vcnt_reg >= delay));
    assign last       = emit && ((out_cnt_reg + CNT_W'(1)) == total);
    assign cfg_hit    = cfg_we && ((cfg_addr == CFG_KSIZE) || (cfg_addr == CFG_WIDTH)
                        || (cfg_addr == CFG_HEIGHT));

    // Which window rows and columns lie inside the image for this output.
    always_comb
    begin
        for (int d = 0; d < MK; d++)
        begin
            rmask[d] = ((32'(oi_reg) + 32'(off)) >= 32'(d))
                       && ((32'(oi_reg) + 32'(off) - 32'(d)) < 32'(h_eff));
            cmask[d] = ((32'(oj_reg) + 32'(off)) >= 32'(d))
                       && ((32'(oj_reg) + 32'(off) - 32'(d)) < 32'(w_eff));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ksize_reg <= 3'd3;
            width_reg <= CFG_W'(640);
            height_reg <= CFG_W'(480);
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_KSIZE:  ksize_reg  <= cfg_wdata[2:0];
                CFG_WIDTH:  width_reg  <= cfg_wdata;
                CFG_HEIGHT: height_reg <= cfg_wdata;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcnt_reg     <= '0;
            out_cnt_reg  <= '0;
            pc_reg       <= '0;
            oi_reg       <= '0;
            oj_reg       <= '0;
            complete_reg <= 1'b0;
        end
        else if (cfg_hit || last)
        begin
            vcnt_reg     <= '0;
            out_cnt_reg  <= '0;
            pc_reg       <= '0;
            oi_reg       <= '0;
            oj_reg       <= '0;
            complete_reg <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                vcnt_reg <= vcnt_reg + CNT_W'(1);
                if ((WW'(pc_reg) + WW'(1)) == w_eff)
                begin
                    pc_reg <= '0;
                end
                else
                begin
                    pc_reg <= pc_reg + CW'(1);
                end
            end
            if (is_pix && ((vcnt_reg + CNT_W'(1)) == total))
            begin
                complete_reg <= 1'b1;
            end
            if (emit)
            begin
                out_cnt_reg <= out_cnt_reg + CNT_W'(1);
                if ((oj_reg + WW'(1)) == w_eff)
                begin
                    oj_reg <= '0;
                    oi_reg <= oi_reg + HW'(1);
                end
                else
                begin
                    oj_reg <= oj_reg + WW'(1);
                end
            end
        end
    end

    // Coefficient loads travel with the pipeline so that earlier pixels still
    // in flight see the old kernel.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < 5; s++)
            begin
                ctl_reg[s] <= '0;
            end
            cw0_reg <= 1'b0;
            cw1_reg <= 1'b0;
            for (int t = 0; t < NT; t++)
            begin
                kstore_reg[t] <= '0;
            end
        end
        else
        begin
            ctl_reg[0] <= '{emit: emit, last: last};
            for (int s = 1; s < 5; s++)
            begin
                ctl_reg[s] <= ctl_reg[s-1];
            end
            cw0_reg <= acc_in && (req == REQ_COEF) && (32'(in_cidx) < NT);
            cw1_reg <= cw0_reg;
            if (cw1_reg)
            begin
                kstore_reg[cidx1_reg] <= $signed(cval1_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rm0_reg   <= rmask;
        cm0_reg   <= cmask;
        rm1_reg   <= rm0_reg;
        cm1_reg   <= cm0_reg;
        cidx0_reg <= in_cidx;
        cval0_reg <= in_cval;
        cidx1_reg <= cidx0_reg;
        cval1_reg <= cval0_reg;
    end

    // Window age a and row depth d map to kernel position (2off-d, 2off-a).
    always_comb
    begin
        for (int a = 0; a < MK; a++)
        begin
            for (int d = 0; d < MK; d++)
            begin
                coef_tap[a*MK+d] = '0;
                for (int o = 0; o <= HALF; o++)
                begin
                    if ((32'(off) == o) && (d <= 2 * o) && (a <= 2 * o)
                        && rm1_reg[d] && cm1_reg[a])
                    begin
                        coef_tap[a*MK+d] = kstore_reg[(2*o-d)*MK + (2*o-a)];
                    end
                end
            end
        end
    end

    rcc_linebuf #(
        .MAX_KERNEL(MAX_KERNEL),
        .MAX_WIDTH (MAX_WIDTH)
    ) u_linebuf (
        .clk  (clk),
        .rst_n(rst_n),
        .step (step),
        .col  (pc_reg),
        .pix  (in_pix),
        .win  (win)
    );

    always_comb
    begin
        for (int t = 0; t < NT; t++)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                lane_pix[ch][t] = win[t][ch*PIX_W +: PIX_W];
            end
        end
    end

    for (genvar ch = 0; ch < 3; ch++)
    begin : g_lane
        rcc_lane #(
            .MAX_KERNEL(MAX_KERNEL),
            .COEF_FRAC (COEF_FRAC)
        ) u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_valid (ctl_reg[1].emit),
            .pix      (lane_pix[ch]),
            .coef     (coef_tap),
            .out_valid(lane_vld[ch]),
            .out_pix  (lane_out[ch])
        );
    end

    // Merge the three channel lanes into one result in the output queue.
    assign push = ctl_reg[4].emit;
    assign pop  = m_tvalid && m_tready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wptr_reg] <= '{last: ctl_reg[4].last, blue: lane_out[2],
                                    green: lane_out[1], red: lane_out[0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fcnt_reg <= '0;
            used_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + PTR_W'(1);
            end
            fcnt_reg <= fcnt_reg + FCW'(push) - FCW'(pop);
            used_reg <= used_reg + FCW'(emit) - FCW'(pop);
        end
    end

    assign m_tvalid = (fcnt_reg != '0);
    assign m_tdata  = {fifo_reg[rptr_reg].blue, fifo_reg[rptr_reg].green,
                       fifo_reg[rptr_reg].red};
    assign m_tlast  = fifo_reg[rptr_reg].last;

    `RCC_ASSERT(a_lane_align, lane_vld == {3{ctl_reg[4].emit}})
    `RCC_NEVER(a_fifo_overflow, push && !pop && (fcnt_reg == FCW'(OUT_DEPTH)))
    `RCC_ASSERT(a_credit_cover, used_reg >= fcnt_reg)

endmodule
